>>> hdl/pfc_pkg.sv
// pixel format converter: format codes, format descriptors and shared types
package pfc_pkg;

    localparam logic [7:0] FMT_RGB888   = 8'd20;
    localparam logic [7:0] FMT_ARGB8888 = 8'd21;
    localparam logic [7:0] FMT_XRGB8888 = 8'd22;
    localparam logic [7:0] FMT_RGB565   = 8'd23;
    localparam logic [7:0] FMT_XRGB1555 = 8'd24;
    localparam logic [7:0] FMT_ARGB1555 = 8'd25;
    localparam logic [7:0] FMT_ARGB4444 = 8'd26;

    localparam logic [1:0] CFG_SOURCE_FORMAT = 2'd0;
    localparam logic [1:0] CFG_OUTPUT_FORMAT = 2'd1;

    localparam int NUM_CHAN   = 4;     // red, green, blue, alpha
    localparam int RECIP_BITS = 24;
    localparam int RECIP_W    = RECIP_BITS + 1;
    localparam int X_W        = 17;    // v*dmax + smax/2 fits here

    // ceil(2^24 / d): exact quotient for any numerator below 2^16 and d below 2^8
    localparam logic [RECIP_W-1:0] RECIP_1   = RECIP_W'((2**RECIP_BITS + 1 - 1) / 1);
    localparam logic [RECIP_W-1:0] RECIP_15  = RECIP_W'((2**RECIP_BITS + 15 - 1) / 15);
    localparam logic [RECIP_W-1:0] RECIP_31  = RECIP_W'((2**RECIP_BITS + 31 - 1) / 31);
    localparam logic [RECIP_W-1:0] RECIP_63  = RECIP_W'((2**RECIP_BITS + 63 - 1) / 63);
    localparam logic [RECIP_W-1:0] RECIP_255 = RECIP_W'((2**RECIP_BITS + 255 - 1) / 255);

    // channel order in the arrays: 0 red, 1 green, 2 blue, 3 alpha
    typedef struct packed {
        logic [2:0]                    bytes;
        logic [NUM_CHAN-1:0][7:0]      cmax;
        logic [NUM_CHAN-1:0][4:0]      csh;
    } t_fmt_desc;

    typedef struct packed {
        logic s2;
        logic s3;
    } t_pipe_en;

    function automatic t_fmt_desc fmt_lookup(input logic [7:0] code);
        t_fmt_desc d;
        d = '0;
        case (code)
            FMT_RGB888: begin
                d.bytes = 3'd3;
                d.cmax  = {8'd0, 8'd255, 8'd255, 8'd255};
                d.csh   = {5'd0, 5'd0, 5'd8, 5'd16};
            end
            FMT_ARGB8888: begin
                d.bytes = 3'd4;
                d.cmax  = {8'd255, 8'd255, 8'd255, 8'd255};
                d.csh   = {5'd24, 5'd0, 5'd8, 5'd16};
            end
            FMT_XRGB8888: begin
                d.bytes = 3'd4;
                d.cmax  = {8'd0, 8'd255, 8'd255, 8'd255};
                d.csh   = {5'd0, 5'd0, 5'd8, 5'd16};
            end
            FMT_RGB565: begin
                d.bytes = 3'd2;
                d.cmax  = {8'd0, 8'd31, 8'd63, 8'd31};
                d.csh   = {5'd0, 5'd0, 5'd5, 5'd11};
            end
            FMT_XRGB1555: begin
                d.bytes = 3'd2;
                d.cmax  = {8'd0, 8'd31, 8'd31, 8'd31};
                d.csh   = {5'd0, 5'd0, 5'd5, 5'd10};
            end
            FMT_ARGB1555: begin
                d.bytes = 3'd2;
                d.cmax  = {8'd1, 8'd31, 8'd31, 8'd31};
                d.csh   = {5'd15, 5'd0, 5'd5, 5'd10};
            end
            FMT_ARGB4444: begin
                d.bytes = 3'd2;
                d.cmax  = {8'd15, 8'd15, 8'd15, 8'd15};
                d.csh   = {5'd12, 5'd0, 5'd4, 5'd8};
            end
            default: d = '0;
        endcase
        return d;
    endfunction

    function automatic logic fmt_valid(input logic [7:0] code);
        return (code >= FMT_RGB888) && (code <= FMT_ARGB4444);
    endfunction

    function automatic logic [31:0] byte_mask(input logic [2:0] bytes);
        logic [31:0] m;
        case (bytes)
            3'd2:    m = 32'h0000_FFFF;
            3'd3:    m = 32'h00FF_FFFF;
            3'd4:    m = 32'hFFFF_FFFF;
            default: m = 32'h0000_0000;
        endcase
        return m;
    endfunction

    function automatic logic [RECIP_W-1:0] recip(input logic [7:0] smax);
        logic [RECIP_W-1:0] r;
        case (smax)
            8'd1:    r = RECIP_1;
            8'd15:   r = RECIP_15;
            8'd31:   r = RECIP_31;
            8'd63:   r = RECIP_63;
            8'd255:  r = RECIP_255;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> hdl/pfc_rescale.sv
// one channel rescale: multiply-add stage, then reciprocal multiply stage
module pfc_rescale (
    input  logic              i_clk,
    input  pfc_pkg::t_pipe_en i_en,
    input  logic [7:0]        i_v,
    input  logic [7:0]        i_smax,
    input  logic [7:0]        i_dmax,
    output logic [7:0]        o_q
);
    import pfc_pkg::*;

    logic [X_W-1:0]         r_x;
    logic [X_W-1:0]         n_x;
    logic [7:0]             r_q;
    logic [7:0]             n_q;
    logic [X_W+RECIP_W-1:0] w_prod;

    assign n_x    = X_W'(i_v) * X_W'(i_dmax) + X_W'(i_smax >> 1);
    assign w_prod = (X_W+RECIP_W)'(r_x) * (X_W+RECIP_W)'(recip(i_smax));

    // a channel missing in the source takes the output's full scale
    assign n_q = (i_smax == 8'd0) ? i_dmax : w_prod[RECIP_BITS +: 8];

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_x <= n_x;
        end
        if (i_en.s3) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

>>> hdl/pixel_format_converter.sv
// pixel format converter top level: config registers, stream pipeline, packing
// pipeline: input transaction to output valid through extract, multiply-add,
//   reciprocal multiply, and pack into the output register
// throughput: one pixel per cycle unless the output stalls; each stage holds when the
//   stage after it is full and stalled, so bubbles are squeezed out under backpressure
// reset: synchronous active low; clears all valid bits and sets both formats to ARGB8888
module pixel_format_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] source_pixel
    input  logic        i_s_axis_tlast,   // end_of_run
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] result_pixel
    output logic [3:0]  o_m_axis_tuser,   // [2:0] result_bytes, [3] format_error
    output logic        o_m_axis_tlast    // last_result
);
    import pfc_pkg::*;

    logic [7:0] r_src_fmt;
    logic [7:0] r_dst_fmt;

    t_fmt_desc  w_src;
    t_fmt_desc  w_dst;
    logic       w_err;
    logic       w_same;

    logic       r_v1, r_v2, r_v3, r_v4;
    logic       w_en1, w_en2, w_en3, w_en4;
    t_pipe_en   w_en;

    logic [31:0] r1_pix, r2_pix, r3_pix;
    logic        r1_last, r2_last, r3_last;
    logic [NUM_CHAN-1:0][7:0] r1_v;
    logic [NUM_CHAN-1:0][7:0] n1_v;
    logic [NUM_CHAN-1:0][7:0] w_q;
    logic [31:0] n1_pix;

    logic [31:0] r_result;
    logic [31:0] n_result;
    logic [31:0] w_packed;
    logic [2:0]  r_bytes;
    logic        r_err;
    logic        r_last;

    // config registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_fmt <= FMT_ARGB8888;
            r_dst_fmt <= FMT_ARGB8888;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SOURCE_FORMAT: r_src_fmt <= i_cfg_data;
                CFG_OUTPUT_FORMAT: r_dst_fmt <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // the user must change formats only while the pipeline is empty; the block does not enforce it
    assign w_src  = fmt_lookup(r_src_fmt);
    assign w_dst  = fmt_lookup(r_dst_fmt);
    assign w_err  = !fmt_valid(r_src_fmt) || !fmt_valid(r_dst_fmt);
    assign w_same = (r_src_fmt == r_dst_fmt);

    // stage enables: a stage moves when it is empty or the next one moves
    assign w_en4 = !r_v4 || i_m_axis_tready;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;
    assign w_en  = '{s2: w_en2, s3: w_en3};

    assign o_s_axis_tready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_s_axis_tvalid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
        end
    end

    // stage 1: cut to source bytes and extract channels
    assign n1_pix = i_s_axis_tdata & byte_mask(w_src.bytes);

    always_comb begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            n1_v[c] = 8'(n1_pix >> w_src.csh[c]) & w_src.cmax[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_pix  <= n1_pix;
            r1_v    <= n1_v;
            r1_last <= i_s_axis_tlast;
        end
        if (w_en2) begin
            r2_pix  <= r1_pix;
            r2_last <= r1_last;
        end
        if (w_en3) begin
            r3_pix  <= r2_pix;
            r3_last <= r2_last;
        end
    end

    // stages 2 and 3: per-channel rescale
    for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
        pfc_rescale u_rescale (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_v    (r1_v[c]),
            .i_smax (w_src.cmax[c]),
            .i_dmax (w_dst.cmax[c]),
            .o_q    (w_q[c])
        );
    end

    // stage 4: pack into the output format, pass the pixel through if formats match, zero on error
    always_comb begin
        w_packed = '0;
        for (int c = 0; c < NUM_CHAN; c++) begin
            w_packed = w_packed | (32'(w_q[c]) << w_dst.csh[c]);
        end
        if (w_err) begin
            n_result = '0;
        end else if (w_same) begin
            n_result = r3_pix;
        end else begin
            n_result = w_packed & byte_mask(w_dst.bytes);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_result <= n_result;
            r_bytes  <= w_err ? 3'd0 : w_dst.bytes;
            r_err    <= w_err;
            r_last   <= r3_last;
        end
    end

    assign o_m_axis_tvalid = r_v4;
    assign o_m_axis_tdata  = r_result;
    assign o_m_axis_tuser  = {r_err, r_bytes};
    assign o_m_axis_tlast  = r_last;

endmodule

>>> hdl/pfc_checker.sv
// port-level checks for the pixel format converter, bound to the top level
module pfc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] i_m_tdata,
    input logic [3:0]  i_m_tuser
);

    // a stalled output transaction stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("output transaction dropped or changed under stall");

    // bad format gives an empty pixel
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser[3] |-> i_m_tdata == 32'd0 && i_m_tuser[2:0] == 3'd0)
        else $error("format error with nonzero pixel or byte count");

    // valid formats always report 2, 3 or 4 bytes
    a_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tuser[3] |->
            i_m_tuser[2:0] == 3'd2 || i_m_tuser[2:0] == 3'd3 || i_m_tuser[2:0] == 3'd4)
        else $error("bad byte count");

    // bits above the byte count are clear
    a_trunc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (i_m_tuser[2:0] == 3'd2 || i_m_tuser[2:0] == 3'd3) |->
            i_m_tdata[31:24] == 8'd0 &&
            (i_m_tuser[2:0] == 3'd3 || i_m_tdata[23:16] == 8'd0))
        else $error("result pixel wider than its byte count");

endmodule

bind pixel_format_converter pfc_checker u_pfc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tuser  (o_m_axis_tuser)
);
